// ----- hw/rtl/psw_pkg.sv -----
`default_nettype none

package psw_pkg;

    localparam int unsigned COORD_W = 11;
    localparam int unsigned CLIP_W = 10;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned MASK_W = 4;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [ADDR_W-1:0] ROW_BYTES = 16'd80;

    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_OFFSET = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR = 3'd5;

    localparam logic [CLIP_W-1:0] CLIP_LEFT_RESET = 10'd0;
    localparam logic [CLIP_W-1:0] CLIP_RIGHT_RESET = 10'd320;
    localparam logic [CLIP_W-1:0] CLIP_TOP_RESET = 10'd0;
    localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RESET = 10'd240;
    localparam logic [ADDR_W-1:0] PAGE_OFFSET_RESET = 16'd0;
    localparam logic [COLOR_W-1:0] FILL_COLOR_RESET = 8'd0;

    localparam logic [MASK_W-1:0] FULL_MASK = 4'h0F;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [COUNT_W-1:0] n;
        logic [MASK_W-1:0] lmask;
        logic [MASK_W-1:0] rmask;
    } span_t;

    function automatic logic [MASK_W-1:0] left_edge_mask(input logic [1:0] sel);
        logic [MASK_W-1:0] m;
        unique case (sel)
            2'd0: m = 4'h0F;
            2'd1: m = 4'h0E;
            2'd2: m = 4'h0C;
            2'd3: m = 4'h08;
        endcase
        return m;
    endfunction

    function automatic logic [MASK_W-1:0] right_edge_mask(input logic [1:0] sel);
        logic [MASK_W-1:0] m;
        unique case (sel)
            2'd0: m = 4'h01;
            2'd1: m = 4'h03;
            2'd2: m = 4'h07;
            2'd3: m = 4'h0F;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/planar_span_write_generator.sv -----
// path: a span passes the input register and the span stage before its first write reaches the write output register
// throughput: one write transaction per cycle while wr_stall is low; a span gives 1 to 3 writes
// a span clipped to nothing is consumed by the input stage and gives no write
// the span stage (one write per cycle unless the output stalls) sets the rate; the address multiply sits before it
// reset: asynchronous active low; clears valids and loads the clip, page and color defaults
`default_nettype none

module planar_span_write_generator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [psw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [psw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                span_valid,
    output logic                                     span_stall,
    input  wire logic signed [psw_pkg::COORD_W-1:0]  row_y,
    input  wire logic signed [psw_pkg::COORD_W-1:0]  span_first_x,
    input  wire logic signed [psw_pkg::COORD_W-1:0]  span_last_x,
    output logic                                     wr_valid,
    input  wire logic                                wr_stall,
    output logic [psw_pkg::ADDR_W-1:0]               byte_address,
    output logic [psw_pkg::MASK_W-1:0]               plane_mask,
    output logic [psw_pkg::COUNT_W-1:0]              byte_count,
    output logic [psw_pkg::COLOR_W-1:0]              write_value,
    output logic                                     last_write
);

    localparam logic [1:0] PH_ONE = 2'd0;
    localparam logic [1:0] PH_LEFT = 2'd1;
    localparam logic [1:0] PH_MID = 2'd2;
    localparam logic [1:0] PH_RIGHT = 2'd3;

    // configuration
    logic [psw_pkg::CLIP_W-1:0] clip_left_reg;
    logic [psw_pkg::CLIP_W-1:0] clip_right_reg;
    logic [psw_pkg::CLIP_W-1:0] clip_top_reg;
    logic [psw_pkg::CLIP_W-1:0] clip_bottom_reg;
    logic [psw_pkg::ADDR_W-1:0] page_offset_reg;
    logic [psw_pkg::COLOR_W-1:0] fill_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg <= psw_pkg::CLIP_LEFT_RESET;
            clip_right_reg <= psw_pkg::CLIP_RIGHT_RESET;
            clip_top_reg <= psw_pkg::CLIP_TOP_RESET;
            clip_bottom_reg <= psw_pkg::CLIP_BOTTOM_RESET;
            page_offset_reg <= psw_pkg::PAGE_OFFSET_RESET;
            fill_color_reg <= psw_pkg::FILL_COLOR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                psw_pkg::REG_CLIP_LEFT:   clip_left_reg <= cfg_data[psw_pkg::CLIP_W-1:0];
                psw_pkg::REG_CLIP_RIGHT:  clip_right_reg <= cfg_data[psw_pkg::CLIP_W-1:0];
                psw_pkg::REG_CLIP_TOP:    clip_top_reg <= cfg_data[psw_pkg::CLIP_W-1:0];
                psw_pkg::REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[psw_pkg::CLIP_W-1:0];
                psw_pkg::REG_PAGE_OFFSET: page_offset_reg <= cfg_data;
                psw_pkg::REG_FILL_COLOR:  fill_color_reg <= cfg_data[psw_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic in_valid_reg;
    logic signed [psw_pkg::COORD_W-1:0] row_reg;
    logic signed [psw_pkg::COORD_W-1:0] first_reg;
    logic signed [psw_pkg::COORD_W-1:0] last_reg_x;

    // span stage
    logic span_valid_reg;
    logic [1:0] phase_reg;
    psw_pkg::span_t span_reg;

    // write output register
    logic wr_valid_reg;
    logic [psw_pkg::ADDR_W-1:0] addr_reg;
    logic [psw_pkg::MASK_W-1:0] mask_reg;
    logic [psw_pkg::COUNT_W-1:0] count_reg;
    logic last_reg;

    // clip and address from the input register
    logic signed [psw_pkg::COORD_W-1:0] top_s;
    logic signed [psw_pkg::COORD_W-1:0] bottom_s;
    logic signed [psw_pkg::COORD_W-1:0] left_s;
    logic signed [psw_pkg::COORD_W-1:0] right_m1_s;
    logic signed [psw_pkg::COORD_W-1:0] xs_c;
    logic signed [psw_pkg::COORD_W-1:0] xe_c;
    logic vis;
    logic [psw_pkg::CLIP_W-1:0] xs_u;
    logic [psw_pkg::CLIP_W-1:0] xe_u;
    logic [psw_pkg::CLIP_W-1:0] span_diff;
    logic [psw_pkg::ADDR_W-1:0] row_base;
    psw_pkg::span_t span_new;

    always_comb
    begin
        top_s = $signed({1'b0, clip_top_reg});
        bottom_s = $signed({1'b0, clip_bottom_reg});
        left_s = $signed({1'b0, clip_left_reg});
        right_m1_s = $signed({1'b0, clip_right_reg}) - 11'sd1;
        xs_c = (first_reg < left_s) ? left_s : first_reg;
        xe_c = (last_reg_x > right_m1_s) ? right_m1_s : last_reg_x;
        vis = (row_reg >= top_s) && (row_reg < bottom_s) && (xe_c >= xs_c);
        xs_u = xs_c[psw_pkg::CLIP_W-1:0];
        xe_u = xe_c[psw_pkg::CLIP_W-1:0];
        span_diff = xe_u - {xs_u[psw_pkg::CLIP_W-1:2], 2'b00};
        row_base = psw_pkg::ADDR_W'(row_reg[psw_pkg::CLIP_W-1:0]) * psw_pkg::ROW_BYTES;
        span_new.addr = page_offset_reg + row_base
            + psw_pkg::ADDR_W'(xs_u[psw_pkg::CLIP_W-1:2]);
        span_new.n = span_diff[psw_pkg::CLIP_W-1:2];
        span_new.lmask = psw_pkg::left_edge_mask(xs_u[1:0]);
        span_new.rmask = psw_pkg::right_edge_mask(xe_u[1:0]);
    end

    // one write per cycle from the span stage while the output is not stalled
    logic out_ld_ok;
    logic emit;
    logic [psw_pkg::ADDR_W-1:0] e_addr;
    logic [psw_pkg::MASK_W-1:0] e_mask;
    logic [psw_pkg::COUNT_W-1:0] e_count;
    logic e_last;
    logic [1:0] e_phase_next;
    logic span_free;
    logic in_consume;
    logic span_load;
    logic in_load_ok;

    always_comb
    begin
        out_ld_ok = !wr_valid_reg || !wr_stall;
        emit = span_valid_reg && out_ld_ok;
        e_addr = span_reg.addr;
        e_mask = span_reg.lmask;
        e_count = psw_pkg::COUNT_W'(1);
        e_last = 1'b0;
        e_phase_next = PH_RIGHT;
        unique case (phase_reg)
            PH_ONE:
            begin
                e_mask = span_reg.lmask & span_reg.rmask;
                e_last = 1'b1;
            end
            PH_LEFT:
            begin
                e_phase_next = (span_reg.n > psw_pkg::COUNT_W'(1)) ? PH_MID : PH_RIGHT;
            end
            PH_MID:
            begin
                e_addr = span_reg.addr + psw_pkg::ADDR_W'(1);
                e_mask = psw_pkg::FULL_MASK;
                e_count = span_reg.n - psw_pkg::COUNT_W'(1);
            end
            PH_RIGHT:
            begin
                e_addr = span_reg.addr + psw_pkg::ADDR_W'(span_reg.n);
                e_mask = span_reg.rmask;
                e_last = 1'b1;
            end
        endcase
        span_free = !span_valid_reg || (emit && e_last);
        in_consume = in_valid_reg && (!vis || span_free);
        span_load = in_consume && vis;
        in_load_ok = !in_valid_reg || in_consume;
    end

    assign span_stall = !in_load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load_ok)
        begin
            in_valid_reg <= span_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load_ok && span_valid)
        begin
            row_reg <= row_y;
            first_reg <= span_first_x;
            last_reg_x <= span_last_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_valid_reg <= 1'b0;
            phase_reg <= PH_ONE;
        end
        else if (span_load)
        begin
            span_valid_reg <= 1'b1;
            phase_reg <= (span_new.n == '0) ? PH_ONE : PH_LEFT;
        end
        else if (emit)
        begin
            span_valid_reg <= !e_last;
            phase_reg <= e_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (span_load)
        begin
            span_reg <= span_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
        end
        else if (out_ld_ok)
        begin
            wr_valid_reg <= span_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            addr_reg <= e_addr;
            mask_reg <= e_mask;
            count_reg <= e_count;
            last_reg <= e_last;
        end
    end

    assign wr_valid = wr_valid_reg;
    assign byte_address = addr_reg;
    assign plane_mask = mask_reg;
    assign byte_count = count_reg;
    assign write_value = fill_color_reg;
    assign last_write = last_reg;

    // rest of the span stays pending behind a write that is not the last
    a_pending_after_partial: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg && !last_reg |-> span_valid_reg)
        else $error("non-final write without pending span");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> count_reg != '0)
        else $error("zero byte count");

    a_partial_single: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg && mask_reg != psw_pkg::FULL_MASK |-> count_reg == psw_pkg::COUNT_W'(1))
        else $error("partial mask with multi-byte count");

    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid_reg && phase_reg == PH_MID |-> span_reg.n > psw_pkg::COUNT_W'(1))
        else $error("full run phase with short span");

    a_hold_span: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid_reg && wr_valid_reg && wr_stall |=> $stable(phase_reg))
        else $error("span phase moved while output stalled");

endmodule

`default_nettype wire

// ----- tb/psw_checker.sv -----
`timescale 1ns / 1ps

module psw_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [psw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [psw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                span_valid,
    input  wire logic                                span_stall,
    input  wire logic signed [psw_pkg::COORD_W-1:0]  row_y,
    input  wire logic signed [psw_pkg::COORD_W-1:0]  span_first_x,
    input  wire logic signed [psw_pkg::COORD_W-1:0]  span_last_x,
    input  wire logic                                wr_valid,
    input  wire logic                                wr_stall,
    input  wire logic [psw_pkg::ADDR_W-1:0]          byte_address,
    input  wire logic [psw_pkg::MASK_W-1:0]          plane_mask,
    input  wire logic [psw_pkg::COUNT_W-1:0]         byte_count,
    input  wire logic [psw_pkg::COLOR_W-1:0]         write_value,
    input  wire logic                                last_write,
    output int                                       fail_count,
    output int                                       pending,
    output int                                       span_count,
    output int                                       drawn_count,
    output int                                       write_count
);

    typedef struct packed {
        logic [psw_pkg::ADDR_W-1:0]  addr;
        logic [psw_pkg::MASK_W-1:0]  mask;
        logic [psw_pkg::COUNT_W-1:0] count;
        logic [psw_pkg::COLOR_W-1:0] value;
        logic                        last;
    } plane_write_t;

    plane_write_t planned_writes[$];

    logic [psw_pkg::CLIP_W-1:0]  win_left;
    logic [psw_pkg::CLIP_W-1:0]  win_right;
    logic [psw_pkg::CLIP_W-1:0]  win_top;
    logic [psw_pkg::CLIP_W-1:0]  win_bottom;
    logic [psw_pkg::ADDR_W-1:0]  page_base;
    logic [psw_pkg::COLOR_W-1:0] color;

    int fails = 0;
    int queued = 0;
    int spans = 0;
    int drawn = 0;
    int writes = 0;

    assign fail_count  = fails;
    assign pending     = queued;
    assign span_count  = spans;
    assign drawn_count = drawn;
    assign write_count = writes;

    task automatic report_mismatch(input string text);
        $display("ERROR at %0t: %s", $realtime, text);
        fails++;
    endtask

    function automatic logic [psw_pkg::MASK_W-1:0] first_byte_mask(input int col);
        case (col & 3)
            0: return 4'hF;
            1: return 4'hE;
            2: return 4'hC;
            default: return 4'h8;
        endcase
    endfunction

    function automatic logic [psw_pkg::MASK_W-1:0] final_byte_mask(input int col);
        case (col & 3)
            0: return 4'h1;
            1: return 4'h3;
            2: return 4'h7;
            default: return 4'hF;
        endcase
    endfunction

    task automatic plan_span_writes(
        input logic signed [psw_pkg::COORD_W-1:0] y,
        input logic signed [psw_pkg::COORD_W-1:0] xs,
        input logic signed [psw_pkg::COORD_W-1:0] xe
    );
        int row;
        int first;
        int final_col;
        int n;
        logic [psw_pkg::ADDR_W-1:0] base;
        logic [psw_pkg::MASK_W-1:0] lmask;
        logic [psw_pkg::MASK_W-1:0] rmask;
        row = y;
        first = xs;
        final_col = xe;
        if (row < int'(win_top) || row >= int'(win_bottom))
            return;
        if (first < int'(win_left))
            first = int'(win_left);
        if (final_col >= int'(win_right))
            final_col = int'(win_right) - 1;
        if (final_col < first)
            return;
        drawn++;
        base = page_base + psw_pkg::ADDR_W'(row * int'(psw_pkg::ROW_BYTES))
             + psw_pkg::ADDR_W'(first >> 2);
        lmask = first_byte_mask(first);
        rmask = final_byte_mask(final_col);
        n = (final_col - (first & ~3)) >> 2;
        if (n == 0) begin
            planned_writes.push_back(plane_write_t'{base, lmask & rmask, 8'd1, color, 1'b1});
        end
        else begin
            planned_writes.push_back(plane_write_t'{base, lmask, 8'd1, color, 1'b0});
            if (n > 1)
                planned_writes.push_back(plane_write_t'{base + 16'd1, psw_pkg::FULL_MASK,
                                                        psw_pkg::COUNT_W'(n - 1), color,
                                                        1'b0});
            planned_writes.push_back(plane_write_t'{base + psw_pkg::ADDR_W'(n), rmask, 8'd1,
                                                    color, 1'b1});
        end
    endtask

    task automatic check_write();
        plane_write_t want;
        writes++;
        if (planned_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write: address %h mask %h count %0d",
                                      byte_address, plane_mask, byte_count));
            return;
        end
        want = planned_writes.pop_front();
        if (byte_address !== want.addr)
            report_mismatch($sformatf("write %0d byte_address %h, expected %h",
                                      writes, byte_address, want.addr));
        if (plane_mask !== want.mask)
            report_mismatch($sformatf("write %0d plane_mask %h, expected %h",
                                      writes, plane_mask, want.mask));
        if (byte_count !== want.count)
            report_mismatch($sformatf("write %0d byte_count %0d, expected %0d",
                                      writes, byte_count, want.count));
        if (write_value !== want.value)
            report_mismatch($sformatf("write %0d write_value %h, expected %h",
                                      writes, write_value, want.value));
        if (last_write !== want.last)
            report_mismatch($sformatf("write %0d last_write %b, expected %b",
                                      writes, last_write, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_left   = psw_pkg::CLIP_LEFT_RESET;
            win_right  = psw_pkg::CLIP_RIGHT_RESET;
            win_top    = psw_pkg::CLIP_TOP_RESET;
            win_bottom = psw_pkg::CLIP_BOTTOM_RESET;
            page_base  = psw_pkg::PAGE_OFFSET_RESET;
            color      = psw_pkg::FILL_COLOR_RESET;
        end
        else begin
            if (wr_valid && !wr_stall)
                check_write();
            if (cfg_write) begin
                case (cfg_index)
                    psw_pkg::REG_CLIP_LEFT:   win_left   = cfg_data[psw_pkg::CLIP_W-1:0];
                    psw_pkg::REG_CLIP_RIGHT:  win_right  = cfg_data[psw_pkg::CLIP_W-1:0];
                    psw_pkg::REG_CLIP_TOP:    win_top    = cfg_data[psw_pkg::CLIP_W-1:0];
                    psw_pkg::REG_CLIP_BOTTOM: win_bottom = cfg_data[psw_pkg::CLIP_W-1:0];
                    psw_pkg::REG_PAGE_OFFSET: page_base  = cfg_data[psw_pkg::ADDR_W-1:0];
                    psw_pkg::REG_FILL_COLOR:  color      = cfg_data[psw_pkg::COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (span_valid && !span_stall) begin
                spans++;
                plan_span_writes(row_y, span_first_x, span_last_x);
            end
            queued = planned_writes.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic [psw_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [psw_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int DRAWN_PER_PHASE = 24;
    localparam int RANDOM_PHASES = 5;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [psw_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [psw_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                span_valid = 1'b0;
    logic signed [psw_pkg::COORD_W-1:0]  row_y = '0;
    logic signed [psw_pkg::COORD_W-1:0]  span_first_x = '0;
    logic signed [psw_pkg::COORD_W-1:0]  span_last_x = '0;
    logic                                wr_stall = 1'b0;

    logic                                span_stall;
    logic                                wr_valid;
    logic [psw_pkg::ADDR_W-1:0]          byte_address;
    logic [psw_pkg::MASK_W-1:0]          plane_mask;
    logic [psw_pkg::COUNT_W-1:0]         byte_count;
    logic [psw_pkg::COLOR_W-1:0]         write_value;
    logic                                last_write;

    int fail_count;
    int pending;
    int span_count;
    int drawn_count;
    int write_count;

    // idling on both sides, switched off for one whole phase
    bit gaps_on = 1'b1;
    int settings_used = 1;

    // window as last loaded, used to aim the random spans
    int win_l = psw_pkg::CLIP_LEFT_RESET;
    int win_r = psw_pkg::CLIP_RIGHT_RESET;
    int win_t = psw_pkg::CLIP_TOP_RESET;
    int win_b = psw_pkg::CLIP_BOTTOM_RESET;

    planar_span_write_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .span_valid   (span_valid),
        .span_stall   (span_stall),
        .row_y        (row_y),
        .span_first_x (span_first_x),
        .span_last_x  (span_last_x),
        .wr_valid     (wr_valid),
        .wr_stall     (wr_stall),
        .byte_address (byte_address),
        .plane_mask   (plane_mask),
        .byte_count   (byte_count),
        .write_value  (write_value),
        .last_write   (last_write)
    );

    psw_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .span_valid   (span_valid),
        .span_stall   (span_stall),
        .row_y        (row_y),
        .span_first_x (span_first_x),
        .span_last_x  (span_last_x),
        .wr_valid     (wr_valid),
        .wr_stall     (wr_stall),
        .byte_address (byte_address),
        .plane_mask   (plane_mask),
        .byte_count   (byte_count),
        .write_value  (write_value),
        .last_write   (last_write),
        .fail_count   (fail_count),
        .pending      (pending),
        .span_count   (span_count),
        .drawn_count  (drawn_count),
        .write_count  (write_count)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        wr_stall <= gaps_on && ($urandom_range(99) < 7);

    initial
    begin
        #2ms;
        $display("timeout with %0d writes outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [psw_pkg::COORD_W-1:0] to_coord(input int v);
        if (v < -1024)
            return -11'sd1024;
        if (v > 1023)
            return 11'sd1023;
        return psw_pkg::COORD_W'(v);
    endfunction

    task automatic send_span(input int y, input int xs, input int xe);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 7) begin
            span_valid <= 1'b0;
            @(negedge clk);
        end
        span_valid   <= 1'b1;
        row_y        <= to_coord(y);
        span_first_x <= to_coord(xs);
        span_last_x  <= to_coord(xe);
        do
            @(posedge clk);
        while (span_stall);
    endtask

    // lowers valid and waits out every planned write plus the pipeline depth
    task automatic drain();
        int guard;
        guard = 0;
        @(negedge clk);
        span_valid <= 1'b0;
        while (pending != 0 && guard < 5000) begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic put_reg(input logic [psw_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [psw_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic load_window(input int left, input int right, input int top, input int bottom,
                               input int page, input int fill);
        put_reg(psw_pkg::REG_CLIP_LEFT, {6'($urandom), 10'(left)});
        put_reg(psw_pkg::REG_CLIP_RIGHT, {6'($urandom), 10'(right)});
        put_reg(psw_pkg::REG_CLIP_TOP, {6'($urandom), 10'(top)});
        put_reg(psw_pkg::REG_CLIP_BOTTOM, {6'($urandom), 10'(bottom)});
        put_reg(psw_pkg::REG_PAGE_OFFSET, 16'(page));
        put_reg(psw_pkg::REG_FILL_COLOR, {8'($urandom), 8'(fill)});
        // writes to the unused indexes must change nothing
        put_reg(REG_SPARE_LO, 16'($urandom));
        put_reg(REG_SPARE_HI, 16'($urandom));
        @(negedge clk);
        cfg_write <= 1'b0;
        win_l = left;
        win_r = right;
        win_t = top;
        win_b = bottom;
        settings_used++;
    endtask

    task automatic random_span();
        int pick;
        int lo;
        int hi;
        int y;
        int xs;
        int xe;
        pick = $urandom_range(99);
        lo = win_l - 8;
        hi = win_r + 8;
        xs = lo + int'($urandom_range(hi - lo));
        if ($urandom_range(1))
            xe = xs + int'($urandom_range(9));
        else
            xe = xs + int'($urandom_range(hi - lo));
        if (pick < 80)
            y = $urandom_range(win_b - 1, win_t);
        else if (pick < 90)
            y = $urandom_range(1) ? win_t - 1 - int'($urandom_range(3))
                                  : win_b + int'($urandom_range(3));
        else begin
            y  = $signed(11'($urandom));
            xs = $signed(11'($urandom));
            xe = $signed(11'($urandom));
        end
        send_span(y, xs, xe);
    endtask

    initial
    begin
        int left;
        int top;
        int tries;
        int start;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset window: row limits, clipping, one byte, two bytes, three writes, empty
        send_span(0, 0, 319);
        send_span(-1024, -1024, 1023);
        send_span(-1, 0, 10);
        send_span(240, 0, 10);
        send_span(239, -1024, 1023);
        send_span(5, 5, 5);
        send_span(6, 3, 4);
        send_span(7, 0, 3);
        send_span(8, 2, 13);
        send_span(9, 10, 5);
        send_span(10, 1023, -1024);
        send_span(11, 318, 1023);
        send_span(1023, 0, 3);
        drain();

        // widest window, address wrap, largest run
        load_window(0, 1023, 0, 1023, 65535, 255);
        send_span(1022, -1024, 1023);
        send_span(1022, 1020, 1023);
        send_span(1023, 0, 5);
        send_span(0, 4, 7);
        send_span(-1024, 0, 1023);
        drain();

        // right edge at the left edge
        load_window(100, 100, 0, 1023, 1234, 8'hA5);
        send_span(3, -1024, 1023);
        send_span(3, 100, 100);
        drain();

        // both windows inverted
        load_window(1023, 0, 1023, 0, 0, 0);
        send_span(0, 0, 0);
        send_span(1023, 1023, 1023);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_window(0, 320, 0, 240, $urandom_range(65535), $urandom_range(255));
                1: load_window(0, 1023, 0, 1023, 65535 - $urandom_range(200), 255);
                3: begin
                    left = $urandom_range(1000);
                    top = $urandom_range(1000);
                    load_window(left, left + $urandom_range(6, 1), top,
                                top + $urandom_range(20, 1), $urandom_range(65535),
                                $urandom_range(255));
                end
                default: begin
                    left = $urandom_range(1000);
                    top = $urandom_range(1000);
                    load_window(left, $urandom_range(1023, left + 1), top,
                                $urandom_range(1023, top + 1), $urandom_range(65535),
                                $urandom_range(255));
                end
            endcase
            gaps_on = (phase != 2);
            start = drawn_count;
            tries = 0;
            while (drawn_count - start < DRAWN_PER_PHASE && tries < 300) begin
                random_span();
                tries++;
            end
            drain();
        end
        gaps_on = 1'b1;

        $display("%0d spans sent over %0d register settings, %0d of them drawn",
                 span_count, settings_used, drawn_count);
        $display("%0d planar writes checked", write_count);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end
        else begin
            if (pending != 0)
                $display("%0d planned writes never arrived", pending);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
